[src/assert_macros.svh]
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define BWG_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("waypoint generator check failed");

// consequent must hold in the cycle after the antecedent
`define BWG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("waypoint generator check failed");

`endif

[src/bwg_pkg.sv]
// shared widths, register codes and structs of the waypoint generator
package bwg_pkg;

	localparam int DATA_W     = 16;  // coordinate and height width
	localparam int GRID_W     = 12;
	localparam int LANE_W     = 8;
	localparam int MASK_W     = 64;
	localparam int NUM_W      = 6;   // waypoint number
	localparam int MAG_W      = DATA_W + 1;       // magnitude of a coordinate
	localparam int SNAP_W     = DATA_W + 2;       // snapped edge, may pass 16 bits
	localparam int STEP_W     = GRID_W + LANE_W;  // row pitch
	localparam int YACC_W     = STEP_W + 2;       // row position accumulator
	localparam int CFG_IDX_W  = 2;
	localparam int MAX_LANES_DEF = 32;

	localparam logic [GRID_W-1:0] GRID_RST   = GRID_W'(100);
	localparam logic [LANE_W-1:0] LANE_RST   = LANE_W'(1);
	localparam logic [DATA_W-1:0] HEIGHT_RST = DATA_W'(4);
	localparam logic [GRID_W-1:0] GRID_MIN   = GRID_W'(2);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_CELL     = 2'd0,
		REG_LANE_COUNT    = 2'd1,
		REG_CRUISE_HEIGHT = 2'd2,
		REG_LAND_MASK     = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [GRID_W-1:0]        grid_cell;
		logic [LANE_W-1:0]        lane_count;
		logic signed [DATA_W-1:0] cruise_height;
		logic [MASK_W-1:0]        landing_mask;
	} cfg_t;

	// request to the remainder unit
	typedef struct packed {
		logic                     start;
		logic                     round_up;
		logic signed [DATA_W-1:0] operand;
	} rem_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [SNAP_W-1:0] value;
	} rem_rsp_t;

endpackage

[src/bwg_if.sv]
// trigger and waypoint channel interfaces
interface bwg_trig_if;
	import bwg_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] area_x_low;
	logic signed [DATA_W-1:0] area_x_high;
	logic signed [DATA_W-1:0] area_y_low;
	logic signed [DATA_W-1:0] area_y_high;

	modport source(output valid, area_x_low, area_x_high, area_y_low, area_y_high,
		input ready);
	modport sink(input valid, area_x_low, area_x_high, area_y_low, area_y_high,
		output ready);
endinterface

interface bwg_wp_if;
	import bwg_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [NUM_W-1:0]         waypoint_number;
	logic signed [DATA_W-1:0] point_x;
	logic signed [DATA_W-1:0] point_y;
	logic signed [DATA_W-1:0] point_z;
	logic                     reverse_heading;
	logic                     land_flag;
	logic                     last;

	modport source(output valid, waypoint_number, point_x, point_y, point_z,
		reverse_heading, land_flag, last, input ready);
	modport sink(input valid, waypoint_number, point_x, point_y, point_z,
		reverse_heading, land_flag, last, output ready);
endinterface

[src/bwg_rem_unit.sv]
// bit-serial remainder unit that snaps one edge to the grid
module bwg_rem_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bwg_pkg::rem_req_t             req,
	input  logic [bwg_pkg::GRID_W-1:0]    grid_cell,
	output bwg_pkg::rem_rsp_t             rsp
);
	import bwg_pkg::*;

	localparam int CNT_W = $clog2(MAG_W);

	logic                     run_q;
	logic                     fin_q;
	logic                     done_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [MAG_W-1:0]         mag_q;
	logic [GRID_W-1:0]        rem_q;
	logic signed [DATA_W-1:0] a_q;
	logic                     up_q;
	logic signed [SNAP_W-1:0] res_q;

	logic signed [MAG_W-1:0]  a_ext;
	logic [GRID_W:0]          rem_try;
	logic [GRID_W:0]          grid_ext;
	logic [GRID_W-1:0]        rem_nxt;
	logic signed [SNAP_W-1:0] rem_s;
	logic signed [SNAP_W-1:0] dg;
	logic signed [SNAP_W-1:0] delta;
	logic                     rem_zero;

	assign a_ext    = {req.operand[DATA_W-1], req.operand};
	assign grid_ext = {1'b0, grid_cell};
	assign rem_try  = {rem_q, mag_q[MAG_W-1]};

	// restoring step: one compare and subtract per bit
	always_comb begin
		if (rem_try >= grid_ext) begin
			rem_nxt = GRID_W'(rem_try - grid_ext);
		end else begin
			rem_nxt = rem_try[GRID_W-1:0];
		end
	end

	// inward snap from the magnitude remainder
	always_comb begin
		rem_zero = (rem_q == '0);
		rem_s    = $signed({{(SNAP_W-GRID_W){1'b0}}, rem_q});
		dg       = $signed({{(SNAP_W-GRID_W){1'b0}}, grid_cell}) - rem_s;
		if (!a_q[DATA_W-1]) begin
			delta = (up_q && !rem_zero) ? dg : -rem_s;
		end else begin
			delta = (!up_q && !rem_zero) ? -dg : rem_s;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(MAG_W-1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.operand;
			up_q  <= req.round_up;
			rem_q <= '0;
			mag_q <= req.operand[DATA_W-1] ? MAG_W'(-a_ext) : MAG_W'(a_ext);
		end else if (run_q) begin
			rem_q <= rem_nxt;
			mag_q <= {mag_q[MAG_W-2:0], 1'b0};
		end
		if (fin_q) begin
			res_q <= $signed({{(SNAP_W-DATA_W){a_q[DATA_W-1]}}, a_q}) + delta;
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = res_q;

endmodule

[src/bwg_ctrl.sv]
// sequencer: snaps each edge, then walks the rows and emits waypoints
module bwg_ctrl #(
	parameter int MAX_LANES = bwg_pkg::MAX_LANES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bwg_pkg::cfg_t     cfg,
	bwg_trig_if.sink          trig,
	bwg_wp_if.source          wp,
	output bwg_pkg::rem_req_t rem_req,
	input  bwg_pkg::rem_rsp_t rem_rsp
);
	import bwg_pkg::*;

	localparam int ROW_W = $clog2(MAX_LANES + 1);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_STEP  = 5'b00010,
		S_SNAP  = 5'b00100,
		S_CHECK = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	state_t                   state_q;
	logic                     generated_q;
	logic [1:0]               side_q;
	logic signed [DATA_W-1:0] area_q [4];
	logic signed [SNAP_W-1:0] snap_q [4];
	logic [STEP_W-1:0]        step_q;
	logic signed [YACC_W-1:0] y_q;
	logic [ROW_W-1:0]         row_q;
	logic                     k_q;
	logic [NUM_W-1:0]         num_q;

	logic [1:0]               side_sel;
	logic [LANE_W-1:0]        lane_eff;
	logic signed [YACC_W-1:0] y_next;
	logic signed [YACC_W-1:0] yb_ext;
	logic                     last_row;
	logic                     wp_take;
	logic                     trig_take;

	assign trig.ready = (state_q == S_IDLE);
	assign trig_take  = trig.valid && trig.ready;
	assign wp_take    = wp.valid && wp.ready;
	assign lane_eff   = (cfg.lane_count == '0) ? LANE_W'(1) : cfg.lane_count;

	// edges in order: x low, x high, y low, y high; low edges round up
	assign side_sel         = (state_q == S_STEP) ? 2'd0 : side_q + 2'd1;
	assign rem_req.start    = (state_q == S_STEP) ||
		((state_q == S_SNAP) && rem_rsp.done && (side_q != 2'd3));
	assign rem_req.round_up = ~side_sel[0];
	assign rem_req.operand  = area_q[side_sel];

	assign y_next   = y_q + $signed({{(YACC_W-STEP_W){1'b0}}, step_q});
	assign yb_ext   = {{(YACC_W-SNAP_W){snap_q[3][SNAP_W-1]}}, snap_q[3]};
	assign last_row = (row_q == ROW_W'(MAX_LANES-1)) || (y_next > yb_ext);

	assign wp.valid           = (state_q == S_EMIT);
	assign wp.waypoint_number = num_q;
	assign wp.point_x         = (k_q ^ row_q[0]) ? snap_q[1][DATA_W-1:0] :
		snap_q[0][DATA_W-1:0];
	assign wp.point_y         = y_q[DATA_W-1:0];
	assign wp.point_z         = cfg.cruise_height;
	assign wp.reverse_heading = row_q[0];
	assign wp.land_flag       = cfg.landing_mask[num_q];
	assign wp.last            = k_q && last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			generated_q <= 1'b0;
			side_q      <= '0;
			row_q       <= '0;
			k_q         <= 1'b0;
			num_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					// later triggers and a bad grid cell are dropped
					if (trig_take && !generated_q && (cfg.grid_cell >= GRID_MIN)) begin
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					side_q  <= '0;
					state_q <= S_SNAP;
				end
				S_SNAP: begin
					if (rem_rsp.done) begin
						if (side_q == 2'd3) begin
							state_q <= S_CHECK;
						end else begin
							side_q <= side_q + 2'd1;
						end
					end
				end
				S_CHECK: begin
					row_q <= '0;
					k_q   <= 1'b0;
					num_q <= '0;
					if ((snap_q[1] <= snap_q[0]) || (snap_q[3] <= snap_q[2])) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (wp_take) begin
						num_q <= num_q + NUM_W'(1);
						k_q   <= ~k_q;
						if (wp.last) begin
							generated_q <= 1'b1;
							state_q     <= S_IDLE;
						end else if (k_q) begin
							row_q <= row_q + ROW_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (trig_take) begin
			area_q[0] <= trig.area_x_low;
			area_q[1] <= trig.area_x_high;
			area_q[2] <= trig.area_y_low;
			area_q[3] <= trig.area_y_high;
		end
		if (state_q == S_STEP) begin
			step_q <= STEP_W'(cfg.grid_cell) * STEP_W'(lane_eff);
		end
		if ((state_q == S_SNAP) && rem_rsp.done) begin
			snap_q[side_q] <= rem_rsp.value;
		end
		if (state_q == S_CHECK) begin
			y_q <= {{(YACC_W-SNAP_W){snap_q[2][SNAP_W-1]}}, snap_q[2]};
		end else if ((state_q == S_EMIT) && wp_take && k_q) begin
			y_q <= y_next;
		end
	end

endmodule

[src/boustrophedon_waypoint_generator_unit.sv]
// top level of the boustrophedon waypoint generator
// One trigger item carries a rectangle in centimetres. The block snaps the
// lower edges up and the upper edges down to the grid cell, then emits two
// waypoints per row, rows spaced by grid_cell times the lane count (zero means
// one), alternating direction, at most MAX_LANES rows. Only the first trigger
// after reset that yields waypoints has an effect; a grid cell below two, an
// empty snapped area or any trigger after that is taken and dropped. The
// snap of each edge runs in turn through one bit-serial remainder unit (a
// load, 17 compare-subtract steps and a result step), after a start state
// and before a state that checks the snapped area; after that one waypoint
// leaves per cycle while the sink is ready, 2 to 64 waypoints in all. The
// trigger side is not ready from acceptance of a trigger that starts a snap
// until the block is idle again, after the last waypoint or an empty area.
// Configuration registers are written by index through cfg_we / cfg_index /
// cfg_data and must only change while the block is idle.
module boustrophedon_waypoint_generator_unit #(
	parameter int MAX_LANES = bwg_pkg::MAX_LANES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bwg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bwg_pkg::MASK_W-1:0]      cfg_data,
	bwg_trig_if.sink                        trig,
	bwg_wp_if.source                        wp
);
	import bwg_pkg::*;

	// configuration registers
	logic [GRID_W-1:0]        grid_cell_q;
	logic [LANE_W-1:0]        lane_count_q;
	logic signed [DATA_W-1:0] cruise_height_q;
	logic [MASK_W-1:0]        landing_mask_q;

	cfg_t     cfg;
	rem_req_t rem_req;
	rem_rsp_t rem_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cell_q     <= GRID_RST;
			lane_count_q    <= LANE_RST;
			cruise_height_q <= HEIGHT_RST;
			landing_mask_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_GRID_CELL:     grid_cell_q     <= cfg_data[GRID_W-1:0];
				REG_LANE_COUNT:    lane_count_q    <= cfg_data[LANE_W-1:0];
				REG_CRUISE_HEIGHT: cruise_height_q <= cfg_data[DATA_W-1:0];
				REG_LAND_MASK:     landing_mask_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg.grid_cell     = grid_cell_q;
	assign cfg.lane_count    = lane_count_q;
	assign cfg.cruise_height = cruise_height_q;
	assign cfg.landing_mask  = landing_mask_q;

	// sequencer: edge snapping, empty check, row walk and waypoint output
	bwg_ctrl #(
		.MAX_LANES(MAX_LANES)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.trig   (trig),
		.wp     (wp),
		.rem_req(rem_req),
		.rem_rsp(rem_rsp)
	);

	// shared divider, one edge at a time
	bwg_rem_unit u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (rem_req),
		.grid_cell(grid_cell_q),
		.rsp      (rem_rsp)
	);

endmodule

[src/bwg_chk.sv]
// port-level checker for the waypoint generator, bound to the top level
`include "assert_macros.svh"

module bwg_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            trig_valid,
	input logic                            trig_ready,
	input logic                            wp_valid,
	input logic                            wp_ready,
	input logic                            wp_last,
	input logic [bwg_pkg::NUM_W-1:0]       wp_number,
	input logic signed [bwg_pkg::DATA_W-1:0] wp_x
);
	import bwg_pkg::*;

	// no new trigger while a sequence is being emitted
	`BWG_ASSERT_SAME(a_busy_while_emit, wp_valid, !trig_ready)

	// a taken trigger never shows a waypoint on the next cycle
	`BWG_ASSERT_NEXT(a_no_instant_wp, trig_valid && trig_ready, !wp_valid)

	// the sequence streams without gaps until its last waypoint
	`BWG_ASSERT_NEXT(a_no_gap, wp_valid && wp_ready && !wp_last, wp_valid)

	// the last waypoint ends the output burst
	`BWG_ASSERT_NEXT(a_end_after_last, wp_valid && wp_ready && wp_last, !wp_valid)

	// a stalled waypoint holds
	`BWG_ASSERT_NEXT(a_hold, wp_valid && !wp_ready,
		wp_valid && $stable(wp_number) && $stable(wp_x))

endmodule

bind boustrophedon_waypoint_generator_unit bwg_chk u_bwg_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.trig_valid(trig.valid),
	.trig_ready(trig.ready),
	.wp_valid  (wp.valid),
	.wp_ready  (wp.ready),
	.wp_last   (wp.last),
	.wp_number (wp.waypoint_number),
	.wp_x      (wp.point_x)
);

[verif/bwg_route_checker.sv]
`timescale 1ns / 1ps
// waypoint scoreboard: predicts each trigger's route and checks the waypoint channel
module bwg_route_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bwg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bwg_pkg::MASK_W-1:0]    cfg_data,
	bwg_trig_if                           trig,
	bwg_wp_if                             wp,
	output int                            mismatches,
	output int                            outstanding
);
	import bwg_pkg::*;

	localparam int SHOWN_MAX = 10;

	typedef struct packed {
		logic [NUM_W-1:0]         number;
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		logic signed [DATA_W-1:0] z;
		logic                     rev;
		logic                     land;
		logic                     last;
	} waypoint_t;

	logic [GRID_W-1:0]        cell_size;
	logic [LANE_W-1:0]        lane_pitch;
	logic signed [DATA_W-1:0] height;
	logic [MASK_W-1:0]        land_mask;
	logic                     route_done;
	waypoint_t                route_q[$];
	int                       fail_count;

	function automatic int snap_up(input int v, input int g);
		int q;
		q = v / g;
		if (v % g != 0 && v > 0)
			q = q + 1;
		return q * g;
	endfunction

	function automatic int snap_down(input int v, input int g);
		int q;
		q = v / g;
		if (v % g != 0 && v < 0)
			q = q - 1;
		return q * g;
	endfunction

	// serpentine route over the snapped rectangle, two waypoints per row
	function automatic void plan_route(input int xl, input int xh, input int yl, input int yh);
		int        g, pitch, x0, x1, y0, y1, rows, n, r, k;
		waypoint_t pt;
		if (route_done || cell_size < GRID_MIN)
			return;
		g     = int'(cell_size);
		pitch = g * ((lane_pitch == '0) ? 1 : int'(lane_pitch));
		x0    = snap_up(xl, g);
		x1    = snap_down(xh, g);
		y0    = snap_up(yl, g);
		y1    = snap_down(yh, g);
		if (x1 <= x0 || y1 <= y0)
			return;
		rows = (y1 - y0) / pitch + 1;
		if (rows > MAX_LANES_DEF)
			rows = MAX_LANES_DEF;
		n = 0;
		for (r = 0; r < rows; r++) begin
			for (k = 0; k < 2; k++) begin
				pt.number = NUM_W'(n);
				pt.rev    = r[0];
				pt.x      = DATA_W'(((k == 0) != pt.rev) ? x0 : x1);
				pt.y      = DATA_W'(y0 + r * pitch);
				pt.z      = height;
				pt.land   = land_mask[n];
				pt.last   = (r == rows - 1 && k == 1);
				route_q.push_back(pt);
				n++;
			end
		end
		route_done = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		waypoint_t got, want;
		if (!arst_n) begin
			cell_size  = GRID_RST;
			lane_pitch = LANE_RST;
			height     = HEIGHT_RST;
			land_mask  = '0;
			route_done = 1'b0;
			fail_count = 0;
			route_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_GRID_CELL:     cell_size  = cfg_data[GRID_W-1:0];
					REG_LANE_COUNT:    lane_pitch = cfg_data[LANE_W-1:0];
					REG_CRUISE_HEIGHT: height     = cfg_data[DATA_W-1:0];
					REG_LAND_MASK:     land_mask  = cfg_data;
					default: ;
				endcase
			end
			if (trig.valid && trig.ready)
				plan_route(int'(trig.area_x_low), int'(trig.area_x_high),
					int'(trig.area_y_low), int'(trig.area_y_high));
			if (wp.valid && wp.ready) begin
				got.number = wp.waypoint_number;
				got.x      = wp.point_x;
				got.y      = wp.point_y;
				got.z      = wp.point_z;
				got.rev    = wp.reverse_heading;
				got.land   = wp.land_flag;
				got.last   = wp.last;
				if (route_q.size() == 0) begin
					fail_count++;
					if (fail_count <= SHOWN_MAX)
						$display("waypoint with none pending: num=%0d x=%0d y=%0d z=%0d",
							got.number, got.x, got.y, got.z);
				end else begin
					want = route_q.pop_front();
					if (got.number !== want.number || got.x !== want.x || got.y !== want.y ||
							got.z !== want.z || got.rev !== want.rev ||
							got.land !== want.land || got.last !== want.last) begin
						fail_count++;
						if (fail_count <= SHOWN_MAX) begin
							$display("waypoint mismatch: want num=%0d x=%0d y=%0d z=%0d %s",
								want.number, want.x, want.y, want.z, "flags below");
							$display("  want rev=%0b land=%0b last=%0b",
								want.rev, want.land, want.last);
							$display("  got  num=%0d x=%0d y=%0d z=%0d rev=%0b land=%0b last=%0b",
								got.number, got.x, got.y, got.z, got.rev, got.land,
								got.last);
						end
					end
				end
			end
		end
		mismatches  <= fail_count;
		outstanding <= route_q.size();
	end

endmodule

[verif/boustrophedon_waypoint_generator_unit_tb.sv]
`timescale 1ns / 1ps
// testbench top: trigger and register stimulus, waypoint sink pacing, verdict
module boustrophedon_waypoint_generator_unit_tb;
	import bwg_pkg::*;

	localparam int IDLE_LIMIT    = 3000;  // cycles with no item moving on either side
	localparam int SETTLE_CYCLES = 200;   // covers a trigger that snaps to nothing
	localparam int HOLD_CYCLES   = 400;   // long sink back-pressure
	localparam int MAX_GAP       = 18;
	localparam int PHASE_ITEMS   = 40;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [MASK_W-1:0]    cfg_data;
	int                   mismatches;
	int                   outstanding;
	int                   idle_cycles = 0;
	int                   taken;
	bit                   steady_sender;

	bwg_trig_if trig_ch ();
	bwg_wp_if   wp_ch ();

	boustrophedon_waypoint_generator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.trig      (trig_ch),
		.wp        (wp_ch)
	);

	bwg_route_checker scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.trig        (trig_ch),
		.wp          (wp_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// 20 ns clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// offer one trigger item and hold it until the block takes it;
	// valid stays high between back-to-back items
	task automatic send_area(input int xl, input int xh, input int yl, input int yh);
		int gap;
		gap = steady_sender ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			trig_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		trig_ch.valid       <= 1'b1;
		trig_ch.area_x_low  <= DATA_W'(xl);
		trig_ch.area_x_high <= DATA_W'(xh);
		trig_ch.area_y_low  <= DATA_W'(yl);
		trig_ch.area_y_high <= DATA_W'(yh);
		do @(posedge clk); while (!trig_ch.ready);
	endtask

	// wait until the block is idle: no route pending and any snap in flight done
	task automatic drain();
		trig_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// all four registers, one per cycle, enable dropped once at the end
	task automatic write_settings(input logic [GRID_W-1:0] g, input logic [LANE_W-1:0] l,
			input logic signed [DATA_W-1:0] h, input logic [MASK_W-1:0] m);
		cfg_we    <= 1'b1;
		cfg_index <= REG_GRID_CELL;
		cfg_data  <= MASK_W'(g);
		@(posedge clk);
		cfg_index <= REG_LANE_COUNT;
		cfg_data  <= MASK_W'(l);
		@(posedge clk);
		cfg_index <= REG_CRUISE_HEIGHT;
		cfg_data  <= MASK_W'(h);
		@(posedge clk);
		cfg_index <= REG_LAND_MASK;
		cfg_data  <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// either two free values over the full range or a wide low-to-high span
	function automatic void random_span(output logic signed [DATA_W-1:0] lo,
			output logic signed [DATA_W-1:0] hi);
		if ($urandom_range(0, 1) == 0) begin
			lo = DATA_W'($urandom);
			hi = DATA_W'($urandom);
		end else begin
			lo = DATA_W'(int'($urandom_range(0, 32767)) - 32768);
			hi = DATA_W'($urandom_range(0, 32767));
		end
	endfunction

	// span that snaps to nothing: either reversed bounds, or both bounds
	// falling on at most one grid line so the snapped edges meet or cross
	function automatic void empty_span(input int g, output logic signed [DATA_W-1:0] lo,
			output logic signed [DATA_W-1:0] hi);
		int a, b, v, base;
		if ($urandom_range(0, 1) == 0) begin
			a  = int'($urandom_range(0, 65535)) - 32768;
			b  = int'($urandom_range(0, 65535)) - 32768;
			lo = DATA_W'((a > b) ? a : b);
			hi = DATA_W'((a > b) ? b : a);
		end else begin
			v    = int'($urandom_range(0, 65535 - 3 * g)) - 32768;
			base = v - v % g;
			a    = base + int'($urandom_range(1, g));
			b    = a + int'($urandom_range(0, base + 2 * g - 1 - a));
			lo   = DATA_W'(a);
			hi   = DATA_W'(b);
		end
	endfunction

	// trigger whose x span, y span or both come out empty after snapping
	task automatic send_empty_area(input int g);
		logic signed [DATA_W-1:0] xl, xh, yl, yh;
		int                       mode;
		mode = $urandom_range(0, 2);
		random_span(xl, xh);
		random_span(yl, yh);
		if (mode != 1)
			empty_span(g, xl, xh);
		if (mode != 0)
			empty_span(g, yl, yh);
		send_area(int'(xl), int'(xh), int'(yl), int'(yh));
	endtask

	// main stimulus
	initial begin : stimulus
		int                       phase, g, lo;
		logic [LANE_W-1:0]        lane;
		logic signed [DATA_W-1:0] xl, xh, yl, yh;

		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_index           <= REG_GRID_CELL;
		cfg_data            <= '0;
		trig_ch.valid       <= 1'b0;
		trig_ch.area_x_low  <= '0;
		trig_ch.area_x_high <= '0;
		trig_ch.area_y_low  <= '0;
		trig_ch.area_y_high <= '0;
		steady_sender = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, grid 100: rectangles that snap to nothing
		send_area(0, 0, 0, 0);                      // point
		send_area(-32768, 32767, 100, 199);         // y collapses onto one grid line
		send_area(32767, -32768, -32768, 32767);    // reversed x bounds
		send_area(1, 99, -32768, 32767);            // x inside one cell
		send_area(-99, -1, -32768, 32767);          // negative x inside one cell
		send_area(-32768, -32768, 32767, 32767);    // corner extremes
		send_area(100, 199, 0, 32767);              // x touches a single grid line

		// grid cell zero: invalid, every trigger dropped
		drain();
		write_settings(12'd0, 8'd0, 16'sh8000, 64'hFFFF_FFFF_FFFF_FFFF);
		send_area(-32768, 32767, -32768, 32767);
		send_area(0, 1000, 0, 1000);

		// grid cell one: still invalid
		drain();
		write_settings(12'd1, 8'd255, 16'sh7FFF, 64'h5555_5555_5555_5555);
		send_area(-32768, 32767, -32768, 32767);
		send_area(-500, 500, -500, 500);

		// largest grid cell with empty snaps
		drain();
		write_settings(12'd4095, 8'd255, 16'sh0000, 64'h0);
		send_area(1, 4094, -32768, 32767);
		send_area(-32768, 32767, -4094, -1);
		send_area(32767, -32768, 32767, -32768);

		// random phases, each with its own settings; every area snaps empty so
		// the one-shot route stays armed for the end
		for (phase = 0; phase < 6; phase++) begin
			drain();
			case (phase)
				0:       g = 2;
				1:       g = 4095;
				2:       g = $urandom_range(2, 30);
				default: g = $urandom_range(2, 400);
			endcase
			lane = (phase == 0) ? 8'd0 : (phase == 1) ? 8'd255 : LANE_W'($urandom_range(0, 255));
			write_settings(GRID_W'(g), lane, DATA_W'($urandom), {$urandom, $urandom});
			steady_sender = (phase == 2);   // one phase with no sender gaps
			repeat (PHASE_ITEMS) send_empty_area(g);
		end

		// short invalid-grid phase with unrestricted rectangles
		drain();
		steady_sender = 1'b0;
		write_settings(12'd1, LANE_W'($urandom), DATA_W'($urandom), {$urandom, $urandom});
		repeat (10) begin
			random_span(xl, xh);
			random_span(yl, yh);
			send_area(int'(xl), int'(xh), int'(yl), int'(yh));
		end

		// the one route of the run: small grid, wide rectangle, many rows,
		// usually hitting the row limit
		drain();
		g = $urandom_range(2, 60);
		write_settings(GRID_W'(g), LANE_W'($urandom_range(0, 2)), DATA_W'($urandom),
			{$urandom, $urandom});
		lo = int'($urandom_range(0, 31768)) - 32768;
		xl = DATA_W'(lo);
		xh = DATA_W'($urandom_range(1000, 32767));
		lo = int'($urandom_range(0, 31768)) - 32768;
		yl = DATA_W'(lo);
		yh = DATA_W'($urandom_range(1000, 32767));
		send_area(int'(xl), int'(xh), int'(yl), int'(yh));

		// later triggers: offered while the sink holds off, then dropped
		repeat (20) begin
			random_span(xl, xh);
			random_span(yl, yh);
			send_area(int'(xl), int'(xh), int'(yl), int'(yh));
		end

		drain();
		if (mismatches == 0 && outstanding == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// waypoint sink: random stalls per item, a stretch with none, and one
	// long hold-off early in the route so the trigger side backs up
	initial begin : sink_pacing
		int gap;
		wp_ch.ready <= 1'b0;
		taken = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			gap = (taken >= 20 && taken < 44) ? 0 : $urandom_range(0, MAX_GAP);
			if (gap > 0) begin
				wp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			wp_ch.ready <= 1'b1;
			do @(posedge clk); while (!wp_ch.valid);
			taken++;
			if (taken == 3) begin
				wp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
		end
	end

	// watchdog: too long with no item moving on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((trig_ch.valid && trig_ch.ready) || (wp_ch.valid && wp_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

endmodule
